[sv/ias_pkg.sv]
// ias_pkg: shared types, widths and constants for the injection angle scheduler.
// Used by every module of the block; depends on nothing.
package ias_pkg;

    localparam int CYLINDERS = 16;
    localparam int CYL_W     = $clog2(CYLINDERS);

    localparam int DIV_NW = 38;    // dividend width (pulse << 17 at most)
    localparam int DIV_DW = 24;    // divisor width (period or rate)
    localparam int DIV_CW = 6;     // step counter width

    localparam logic [16:0] DUTY_MAX  = 17'd131071;
    localparam logic [20:0] ANGLE_MAX = 21'd1048575;

    localparam logic signed [23:0] FULL_CYCLE  = 24'sd46080;
    localparam logic signed [23:0] HALF_CYCLE  = 24'sd23040;
    localparam logic signed [23:0] QUART_CYCLE = 24'sd11520;
    localparam logic signed [23:0] HOLD_WINDOW = 24'sd11520;
    localparam logic signed [23:0] PASS_MARK   = -24'sd5760;

    // register indexes
    localparam logic [2:0] REG_PREPARE = 3'd0;
    localparam logic [2:0] REG_ENDING  = 3'd1;
    localparam logic [2:0] REG_LIMIT   = 3'd2;
    localparam logic [2:0] REG_ACTION  = 3'd3;
    localparam logic [2:0] REG_RSRC    = 3'd4;

    // limit actions
    localparam logic [1:0] LIM_FLAG  = 2'd0;
    localparam logic [1:0] LIM_CUT   = 2'd1;
    localparam logic [1:0] LIM_CLAMP = 2'd2;

    typedef struct packed {
        logic [14:0] prepare_advance;
        logic        phase_is_ending;
        logic [16:0] duty_limit;
        logic [1:0]  limit_action;
        logic        rate_source;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic lp_load;
        logic div_start;
        logic div_sel;
        logic duty_load;
        logic wrap;
        logic angle_load;
        logic eval;
        logic mul;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } stat_t;

endpackage

[sv/injection_angle_scheduler.sv]
// Injection angle scheduler: one crank-event update per input transfer, one
// result transfer per update. Each update runs two 38-step divisions on one
// shared restoring divider (duty against the crank period, then pulse angle
// against the rate), plus load, decision, offset multiply and output steps.
// A new input transfer is taken once the previous update has moved its result
// into the output register, even if that result is not yet taken downstream.
// The user must write configuration through the APB port only while the
// block is idle; the block itself does not enforce this. Registers sit at
// byte addresses 0 (prepare_advance), 4 (phase_is_ending), 8 (duty_limit),
// 12 (limit_action) and 16 (rate_source).
// Depends on ias_pkg, ias_ctrl, ias_dp (and ias_div below it).
module injection_angle_scheduler
    import ias_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cylinder[3:0], crank_position[19:4], target_phase[37:20], lag_time_us[53:38],
    // inject_time_us[73:54], crank_period_us[97:74], event_time[129:98],
    // rate_per_pulse[153:130], rate_per_rev[177:154], zero fill above
    input  logic [183:0] s_tdata,
    // clear_entry[0], sequential[1]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // open_time[31:0], close_time[63:32], pulse_us[84:64], duty[101:85], zero fill
    output logic [103:0] m_tdata,
    // fire[0], over_limit[1]
    output logic [1:0]   m_tuser
);

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register file: write on the access phase of an APB write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prepare_advance <= '0;
            cfg_reg.phase_is_ending <= 1'b0;
            cfg_reg.duty_limit      <= 17'd65535;
            cfg_reg.limit_action    <= LIM_FLAG;
            cfg_reg.rate_source     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_PREPARE: cfg_reg.prepare_advance <= pwdata[14:0];
                REG_ENDING:  cfg_reg.phase_is_ending <= pwdata[0];
                REG_LIMIT:   cfg_reg.duty_limit      <= pwdata[16:0];
                REG_ACTION:  cfg_reg.limit_action    <= pwdata[1:0];
                REG_RSRC:    cfg_reg.rate_source     <= pwdata[0];
                default:     ;
            endcase
        end
    end

    // Read back: return the register at the decoded index, zero elsewhere.
    always_comb
    begin
        case (paddr[4:2])
            REG_PREPARE: prdata = {17'b0, cfg_reg.prepare_advance};
            REG_ENDING:  prdata = {31'b0, cfg_reg.phase_is_ending};
            REG_LIMIT:   prdata = {15'b0, cfg_reg.duty_limit};
            REG_ACTION:  prdata = {30'b0, cfg_reg.limit_action};
            REG_RSRC:    prdata = {31'b0, cfg_reg.rate_source};
            default:     prdata = '0;
        endcase
    end

    // Sequence each update through the shared divider and decision steps.
    ias_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold captured fields, per-cylinder state and the result register.
    ias_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .cfg     (cfg_reg),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

`ifndef SYNTHESIS
    // An accepted update keeps the input side closed while it is worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an update was in progress");

    // A scheduled pulse never has zero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[84:64] != 21'd0))
        else $error("fire with zero pulse length");

    // Without a pulse the activate and deactivate times stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[63:0] == 64'd0))
        else $error("times set without fire");
`endif

endmodule

[sv/ias_div.sv]
// ias_div: restoring divider, one quotient bit per cycle.
// Depends on ias_pkg for widths.
module ias_div
    import ias_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              busy,
    output logic [DIV_NW-1:0] quotient
);

    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_DW:0]   rem_reg, rem_next;
    logic [DIV_NW-1:0] q_reg, q_next;
    logic [DIV_DW-1:0] d_reg, d_next;
    logic [DIV_DW:0]   trial;
    logic              ge;

    always_comb
    begin
        trial    = {rem_reg[DIV_DW-1:0], q_reg[DIV_NW-1]};
        ge       = (trial >= {1'b0, d_reg});
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        d_next   = d_reg;
        if (start)
        begin
            cnt_next = DIV_CW'(DIV_NW);
            rem_next = '0;
            q_next   = dividend;
            d_next   = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = ge ? (trial - {1'b0, d_reg}) : trial;
            q_next   = {q_reg[DIV_NW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;

endmodule

[sv/ias_dp.sv]
// ias_dp: datapath - input capture, duty and angle division, per-cylinder
// state, scheduling decision and output register. Depends on ias_pkg, ias_div.
module ias_dp
    import ias_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    output stat_t        stat,
    input  cfg_t         cfg,
    input  logic [183:0] s_tdata,
    input  logic [1:0]   s_tuser,
    output logic [103:0] m_tdata,
    output logic [1:0]   m_tuser
);

    logic [3:0]         cyl_reg;
    logic               clr_reg, seq_reg;
    logic [15:0]        pos_reg, lag_reg;
    logic signed [17:0] phase_reg, phase_next;
    logic [19:0]        inj_reg;
    logic [23:0]        period_reg, rpp_reg, rpr_reg;
    logic [31:0]        ts_reg;

    logic [40:0]        lp_reg;
    logic [16:0]        duty_reg;
    logic [20:0]        pangle_reg;
    logic               dec_reg, fire_reg, over_reg;
    logic [20:0]        pfin_reg;
    logic signed [23:0] act_reg;
    logic signed [48:0] prod_reg;

    logic [CYLINDERS-1:0] ready_reg, pend_reg, done_reg;
    logic signed [18:0]   angle_reg [CYLINDERS];

    logic [20:0]        pulse;
    logic [DIV_NW-1:0]  num, dividend, quotient;
    logic [DIV_DW-1:0]  divisor;
    logic               busy;

    logic [CYL_W-1:0]   idx;
    logic               ignore, over, early, pass, hold, decide;
    logic signed [23:0] phase_s, pos_s, cyc, half, cur0, prev_s, diff, cur, pang_s, adv, act;
    logic signed [18:0] wrap_t;
    logic [20:0]        clamp, pfin;
    logic [31:0]        open_t;

    assign pulse = {5'b0, lag_reg} + {1'b0, (seq_reg ? inj_reg : {1'b0, inj_reg[19:1]})};
    assign num   = seq_reg ? {1'b0, pulse, 16'b0} : {pulse, 17'b0};
    assign dividend = cmd.div_sel ? {3'b0, pulse, 14'b0} : num;
    assign divisor  = cmd.div_sel ? (cfg.rate_source ? rpr_reg : rpp_reg) : period_reg;

    ias_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (busy),
        .quotient (quotient)
    );
    assign stat.div_busy = busy;

    // phase wrap, one crank-cycle subtraction per step during the duty division
    always_comb
    begin
        half   = seq_reg ? HALF_CYCLE : QUART_CYCLE;
        cyc    = seq_reg ? FULL_CYCLE : HALF_CYCLE;
        wrap_t = 19'(phase_reg) - 19'(cyc);
        phase_next = phase_reg;
        if (cmd.wrap && (24'(phase_reg) > half))
            phase_next = 18'(wrap_t);
    end

    always_comb
    begin
        idx    = cyl_reg[CYL_W-1:0];
        ignore = ({1'b0, cyl_reg} >= 5'(CYLINDERS));
        phase_s = 24'(phase_reg);
        pos_s   = $signed({8'b0, pos_reg});
        cur0    = (pos_s < phase_s) ? (phase_s - pos_s) : (cyc - pos_s + phase_s);
        prev_s  = 24'(angle_reg[idx]);
        diff    = cur0 - prev_s;
        hold    = (diff > 24'sd0) && (diff < HOLD_WINDOW);
        cur     = hold ? prev_s : cur0;
        pang_s  = $signed({3'b0, pangle_reg});
        adv     = $signed({9'b0, cfg.prepare_advance})
                  + (cfg.phase_is_ending ? pang_s : 24'sd0);
        early   = (cur - adv) < 24'sd0;
        pass    = (prev_s - cur) < PASS_MARK;
        act     = cur - (cfg.phase_is_ending ? pang_s : 24'sd0);
        decide  = !ignore && !clr_reg && ready_reg[idx] && !pend_reg[idx]
                  && !done_reg[idx] && early;
        over    = ({3'b0, num} > lp_reg);
        clamp   = seq_reg ? lp_reg[36:16] : lp_reg[37:17];
        pfin    = pulse;
        if (over)
        begin
            case (cfg.limit_action)
                LIM_CUT:   pfin = '0;
                LIM_CLAMP: pfin = clamp;
                default:   pfin = pulse;
            endcase
        end
        open_t = ts_reg + 32'(prod_reg[45:14]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
            pend_reg  <= '0;
            done_reg  <= '0;
            for (int i = 0; i < CYLINDERS; i++)
                angle_reg[i] <= '0;
        end
        else if (cmd.eval && !ignore)
        begin
            if (clr_reg)
            begin
                ready_reg[idx] <= 1'b0;
                pend_reg[idx]  <= 1'b0;
                done_reg[idx]  <= 1'b0;
                angle_reg[idx] <= '0;
            end
            else if (!ready_reg[idx])
            begin
                ready_reg[idx] <= 1'b1;
                pend_reg[idx]  <= 1'b0;
                done_reg[idx]  <= 1'b1;
                angle_reg[idx] <= 19'(cur0);
            end
            else
            begin
                angle_reg[idx] <= 19'(cur);
                if (!pend_reg[idx] && !done_reg[idx])
                begin
                    if (early)
                        pend_reg[idx] <= 1'b1;
                end
                else if (pass)
                begin
                    if (pend_reg[idx])
                    begin
                        done_reg[idx] <= 1'b1;
                        pend_reg[idx] <= 1'b0;
                    end
                end
                else
                    done_reg[idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cyl_reg    <= s_tdata[3:0];
            pos_reg    <= s_tdata[19:4];
            phase_reg  <= $signed(s_tdata[37:20]);
            lag_reg    <= s_tdata[53:38];
            inj_reg    <= s_tdata[73:54];
            period_reg <= s_tdata[97:74];
            ts_reg     <= s_tdata[129:98];
            rpp_reg    <= s_tdata[153:130];
            rpr_reg    <= s_tdata[177:154];
            clr_reg    <= s_tuser[0];
            seq_reg    <= s_tuser[1];
        end
        else
            phase_reg <= phase_next;
        if (cmd.lp_load)
            lp_reg <= {24'b0, cfg.duty_limit} * {17'b0, period_reg};
        if (cmd.duty_load)
            duty_reg <= (quotient > DIV_NW'(DUTY_MAX)) ? DUTY_MAX : quotient[16:0];
        if (cmd.angle_load)
            pangle_reg <= (quotient > DIV_NW'(ANGLE_MAX)) ? ANGLE_MAX : quotient[20:0];
        if (cmd.eval)
        begin
            dec_reg  <= decide;
            fire_reg <= decide && (pfin != '0);
            over_reg <= over;
            pfin_reg <= pfin;
            act_reg  <= act;
        end
        if (cmd.mul)
            prod_reg <= act_reg * $signed({1'b0, rpp_reg});
        if (cmd.out_load)
        begin
            m_tdata[31:0]   <= fire_reg ? open_t : 32'd0;
            m_tdata[63:32]  <= fire_reg ? (open_t + {11'b0, pfin_reg}) : 32'd0;
            m_tdata[84:64]  <= dec_reg ? pfin_reg : 21'd0;
            m_tdata[101:85] <= dec_reg ? duty_reg : 17'd0;
            m_tdata[103:102] <= 2'b0;
            m_tuser[0]      <= fire_reg;
            m_tuser[1]      <= dec_reg && over_reg;
        end
    end

endmodule

[sv/ias_ctrl.sv]
// ias_ctrl: sequencing state machine and output valid flag.
// Depends on ias_pkg for the command and status structs.
module ias_ctrl
    import ias_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_DUTY  = 7'b0000100,
        S_ANGLE = 7'b0001000,
        S_EVAL  = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = s_tvalid;
                if (s_tvalid)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.lp_load   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DUTY;
            end
            S_DUTY:
            begin
                cmd.wrap = 1'b1;
                if (!stat.div_busy)
                begin
                    cmd.duty_load = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = 1'b1;
                    state_next    = S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                cmd.div_sel = 1'b1;
                if (!stat.div_busy)
                begin
                    cmd.angle_load = 1'b1;
                    state_next     = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        valid_next = valid_reg;
        if (cmd.out_load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

endmodule

[tb/ias_checker.sv]
// ias_checker: watches the input and result channels of the injection angle
// scheduler, predicts each result and compares it. Depends on ias_pkg.
module ias_checker
    import ias_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [183:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending_count,
    output int           result_count,
    output int           fire_count
);

    typedef struct packed {
        logic        fire;
        logic [31:0] open_time;
        logic [31:0] close_time;
        logic [20:0] pulse_us;
        logic [16:0] duty;
        logic        over_limit;
    } sched_t;

    cfg_t   cfg;
    sched_t sched_q[$];

    logic              ready_f [CYLINDERS];
    logic              pend_f  [CYLINDERS];
    logic              done_f  [CYLINDERS];
    logic signed [18:0] left_a [CYLINDERS];
    logic              seen_f  [CYLINDERS];

    function automatic longint floor_q14(longint x);
        if (x >= 0)
            return x >>> 14;
        return -((-x + 16383) >>> 14);
    endfunction

    // Advance one cylinder's state for one update and return its schedule.
    function automatic sched_t schedule_update(logic [183:0] d, logic [1:0] u);
        sched_t          r;
        int unsigned     cyl;
        logic            seq;
        longint          pos, phase, cyc, cur, prev, adv, act, off;
        longint unsigned lag, inj, period, ts, rpp, rpr, pulse, num, duty, rate, pang;
        int              dsh;
        logic            over;
        r = '0;
        cyl = d[3:0];
        seq = u[1];
        pos = d[19:4];
        phase = longint'($signed(d[37:20]));
        lag = d[53:38];
        inj = d[73:54];
        period = d[97:74];
        ts = d[129:98];
        rpp = d[153:130];
        rpr = d[177:154];
        if (cyl >= CYLINDERS)
            return r;
        if (u[0])
        begin
            ready_f[cyl] = 0;
            pend_f[cyl] = 0;
            done_f[cyl] = 0;
            left_a[cyl] = 0;
            seen_f[cyl] = 0;
            return r;
        end
        dsh = seq ? 16 : 17;
        cyc = seq ? 46080 : 23040;
        pulse = lag + (seq ? inj : (inj >> 1));
        num = pulse << dsh;
        if (period == 0)
            duty = DUTY_MAX;
        else
        begin
            duty = num / period;
            if (duty > DUTY_MAX)
                duty = DUTY_MAX;
        end
        over = num > longint'(cfg.duty_limit) * period;
        rate = cfg.rate_source ? rpr : rpp;
        if (rate == 0)
            pang = ANGLE_MAX;
        else
        begin
            pang = (pulse << 14) / rate;
            if (pang > ANGLE_MAX)
                pang = ANGLE_MAX;
        end
        adv = longint'(cfg.prepare_advance) + (cfg.phase_is_ending ? longint'(pang) : 0);
        while (phase > cyc / 2)
            phase -= cyc;
        if (pos < phase)
            cur = phase - pos;
        else
            cur = cyc - pos + phase;
        if (!ready_f[cyl])
        begin
            ready_f[cyl] = 1;
            pend_f[cyl] = 0;
            done_f[cyl] = 1;
            left_a[cyl] = cur[18:0];
            return r;
        end
        prev = longint'(left_a[cyl]);
        if (cur - prev > 0 && cur - prev < 11520)
            cur = prev;
        if (!pend_f[cyl] && !done_f[cyl])
        begin
            if (cur - adv < 0)
            begin
                if (over)
                begin
                    seen_f[cyl] = 1;
                    if (cfg.limit_action == LIM_CUT)
                        pulse = 0;
                    else if (cfg.limit_action == LIM_CLAMP)
                        pulse = (longint'(cfg.duty_limit) * period) >> dsh;
                end
                else
                    seen_f[cyl] = 0;
                if (pulse != 0)
                begin
                    act = cur - (cfg.phase_is_ending ? longint'(pang) : 0);
                    off = floor_q14(act * longint'(rpp));
                    r.fire = 1;
                    r.open_time = 32'(ts + off);
                    r.close_time = 32'(r.open_time + pulse);
                end
                r.pulse_us = pulse[20:0];
                r.duty = duty[16:0];
                r.over_limit = over;
                pend_f[cyl] = 1;
            end
        end
        else if (prev - cur < -5760)
        begin
            if (pend_f[cyl])
            begin
                done_f[cyl] = 1;
                pend_f[cyl] = 0;
            end
        end
        else
            done_f[cyl] = 0;
        left_a[cyl] = cur[18:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_t exp_r, got;
        if (!rst_n)
        begin
            cfg.prepare_advance <= '0;
            cfg.phase_is_ending <= 1'b0;
            cfg.duty_limit <= 17'd65535;
            cfg.limit_action <= LIM_FLAG;
            cfg.rate_source <= 1'b0;
            for (int i = 0; i < CYLINDERS; i++)
            begin
                ready_f[i] = 0;
                pend_f[i] = 0;
                done_f[i] = 0;
                left_a[i] = 0;
                seen_f[i] = 0;
            end
            sched_q.delete();
            fail_count <= 0;
            pending_count <= 0;
            result_count <= 0;
            fire_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (paddr[4:2])
                    REG_PREPARE: cfg.prepare_advance <= pwdata[14:0];
                    REG_ENDING:  cfg.phase_is_ending <= pwdata[0];
                    REG_LIMIT:   cfg.duty_limit <= pwdata[16:0];
                    REG_ACTION:  cfg.limit_action <= pwdata[1:0];
                    REG_RSRC:    cfg.rate_source <= pwdata[0];
                    default: ;
                endcase
            end
            // Predict on the input transfer; config is only written while idle.
            if (s_tvalid && s_tready)
                sched_q.push_back(schedule_update(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                got.fire = m_tuser[0];
                got.over_limit = m_tuser[1];
                got.open_time = m_tdata[31:0];
                got.close_time = m_tdata[63:32];
                got.pulse_us = m_tdata[84:64];
                got.duty = m_tdata[101:85];
                result_count <= result_count + 1;
                if (got.fire)
                    fire_count <= fire_count + 1;
                if (sched_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    exp_r = sched_q.pop_front();
                    if (got !== exp_r)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("result mismatch: expected %p got %p", exp_r, got);
                    end
                end
            end
            pending_count <= sched_q.size();
        end
    end

endmodule

[tb/tb.sv]
// tb: stimulus and verdict for the injection angle scheduler. Drives APB
// config and crank-event updates; ias_checker does all prediction.
// Depends on ias_pkg, injection_angle_scheduler and ias_checker.
module tb;
    import ias_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // cylinder, crank_position, target_phase, lag_time_us, inject_time_us,
    // crank_period_us, event_time, rate_per_pulse, rate_per_rev (low bits up)
    logic [183:0] s_tdata = '0;
    // clear_entry, sequential
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // open_time, close_time, pulse_us, duty
    logic [103:0] m_tdata;
    // fire, over_limit
    logic [1:0]   m_tuser;

    int fail_count, pending_count, result_count, fire_count;
    int idle_pct  = 0;   // sender idle chance per cycle
    int stall_pct = 0;   // receiver stall chance per cycle
    longint cycles = 0;
    int updates_sent = 0;

    always #10 clk = ~clk;

    injection_angle_scheduler u_dut (.*);
    ias_checker u_chk (.*);

    // Receiver: stall at random per the current phase.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Setup phase, then access phase, then back to idle before the next write.
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Send one update; hold tvalid until the transfer completes. Drop tvalid
    // only while idling, so back-to-back updates keep it high.
    task automatic send_update(logic [3:0] cyl, logic clr, logic seq, logic [15:0] pos,
                               logic [17:0] ph, logic [15:0] lag, logic [19:0] inj,
                               logic [23:0] per, logic [31:0] ts, logic [23:0] rpp,
                               logic [23:0] rpr);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, rpr, rpp, ts, per, inj, lag, ph, pos, cyl};
        s_tuser <= {seq, clr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        updates_sent++;
    endtask

    // Drop tvalid, drain all expected results, then wait out the block's latency.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic random_update(int sparse_cyl);
        logic [3:0]  cyl;
        logic        seq;
        logic [15:0] pos;
        logic signed [17:0] ph;
        logic [23:0] per, rpp;
        cyl = $urandom_range(sparse_cyl);
        seq = $urandom_range(1);
        pos = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(46080));
        ph = ($urandom_range(9) == 0) ? 18'($urandom) :
             18'($signed($urandom_range(138240)) - 46080);
        per = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(40000, 2000));
        rpp = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(20000, 100));
        send_update(cyl, $urandom_range(40) == 0, seq, pos, ph,
                    ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1500)),
                    ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(20000)),
                    ($urandom_range(50) == 0) ? 24'd0 : per, $urandom,
                    ($urandom_range(50) == 0) ? 24'd0 : rpp,
                    ($urandom_range(50) == 0) ? 24'd0 : 24'($urandom_range(20000, 100)));
    endtask

    // Sweep one cylinder around the cycle so it passes the prepare window.
    task automatic crank_sweep(logic [3:0] cyl, int steps);
        int pos0;
        int ph;
        logic seq;
        seq = $urandom_range(1);
        pos0 = $urandom_range(seq ? 46079 : 23039);
        ph = $urandom_range(seq ? 46080 : 23040);
        for (int k = 0; k < steps; k++)
        begin
            pos0 = (pos0 + $urandom_range(4000, 600)) % (seq ? 46080 : 23040);
            send_update(cyl, 1'b0, seq, 16'(pos0), 18'(ph),
                        16'($urandom_range(1200)), 20'($urandom_range(30000)),
                        24'($urandom_range(30000, 1000)), $urandom,
                        24'($urandom_range(8000, 200)), 24'($urandom_range(8000, 200)));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, clear, first update, zero period and rate.
        reg_write(REG_PREPARE, 32'd23040);
        send_update(4'd0, 1'b0, 1'b1, 16'd0, 18'h0_0000, 16'd0, 20'd0,
                    24'd1, 32'd0, 24'd0, 24'd0);
        send_update(4'd0, 1'b0, 1'b1, 16'd46080, 18'(-46080), 16'hFFFF, 20'hFFFFF,
                    24'hFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_update(4'd0, 1'b0, 1'b0, 16'd100, 18'd92160, 16'd500, 20'd4000,
                    24'd0, 32'h8000_0000, 24'd1000, 24'd0);
        send_update(4'd0, 1'b1, 1'b0, 16'hFFFF, 18'h3FFFF, 16'd1, 20'd1,
                    24'd0, 32'd5, 24'd0, 24'd0);
        send_update(4'd15, 1'b0, 1'b0, 16'd2000, 18'd92160, 16'd300, 20'd8000,
                    24'd10000, 32'd1000, 24'd4000, 24'd3000);
        for (int k = 0; k < 3; k++)
            crank_sweep(4'(k + 1), 6);
        drain();

        // Several config settings, extremes included, each with random traffic.
        for (int phs = 0; phs < 12; phs++)
        begin
            case (phs % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            reg_write(REG_PREPARE, (phs == 0) ? 32'd0 : (phs == 1) ? 32'h7FFF :
                      32'($urandom_range(23040)));
            reg_write(REG_ENDING, phs % 2);
            reg_write(REG_LIMIT, (phs == 2) ? 32'd0 : (phs == 3) ? 32'h1FFFF :
                      32'($urandom_range(131071)));
            reg_write(REG_ACTION, phs % 4);
            reg_write(REG_RSRC, (phs / 2) % 2);
            for (int k = 0; k < 68; k++)
            begin
                if ($urandom_range(3) != 0)
                    crank_sweep(4'($urandom_range(15)), 2);
                else
                    random_update(15);
            end
            drain();
        end
        idle_pct = 0;
        stall_pct = 0;
        drain();

        $display("run covered %0d updates over 12 config settings, %0d results, %0d fires",
                 updates_sent, result_count, fire_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
